>>> sv/assert_macros.svh
// assertion macros used by the allocator datapath module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sfa_pkg.sv
// shared types, codes and constants of the segment fit allocator
package sfa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int RESULT_LIMIT     = 64;

    localparam logic [15:0] UINT16_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RECLAIM = 2'd1;
    localparam logic [1:0] CMD_DUMP    = 2'd2;
    localparam logic [1:0] CMD_INIT    = 2'd3;

    localparam logic [2:0] ST_ALLOC   = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_RECLAIM = 3'd2;
    localparam logic [2:0] ST_BADIDX  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_DUMP    = 3'd5;
    localparam logic [2:0] ST_INIT    = 3'd6;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_NEXT  = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_POLICY = 2'd1;
    localparam logic [1:0] CFG_MEMSZ  = 2'd2;
    localparam logic [1:0] CFG_BLKSZ  = 2'd3;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE       = 5'd0;
    localparam t_op OP_LOAD       = 5'd1;
    localparam t_op OP_INIT_START = 5'd2;
    localparam t_op OP_INIT_STEP  = 5'd3;
    localparam t_op OP_ALC_START  = 5'd4;
    localparam t_op OP_RD_IDX     = 5'd5;
    localparam t_op OP_ALC_CHK    = 5'd6;
    localparam t_op OP_ALC_SEL    = 5'd7;
    localparam t_op OP_RD_NEXT    = 5'd8;
    localparam t_op OP_ALC_MERGE  = 5'd9;
    localparam t_op OP_RD_PREV    = 5'd10;
    localparam t_op OP_SH_WR      = 5'd11;
    localparam t_op OP_ALC_INS    = 5'd12;
    localparam t_op OP_REC_BAD    = 5'd13;
    localparam t_op OP_REC_START  = 5'd14;
    localparam t_op OP_RD_SEL     = 5'd15;
    localparam t_op OP_REC_LATCH  = 5'd16;
    localparam t_op OP_REC_MERGE  = 5'd17;
    localparam t_op OP_RD_AHEAD   = 5'd18;
    localparam t_op OP_RM_WR      = 5'd19;
    localparam t_op OP_RM_FIN     = 5'd20;
    localparam t_op OP_DUMP_START = 5'd21;
    localparam t_op OP_DUMP_EM    = 5'd22;

    typedef struct packed {
        logic [1:0] cmd;
        logic       dyn;
        logic       out_free;
        logic       bad_idx;
        logic       init_done;
        logic       scan_end;
        logic       chk_stop;
        logic       found;
        logic       split;
        logic       merge_ok;
        logic       full;
        logic       sh_end;
        logic       rm_end;
        logic       dump_last;
    } t_sts;

endpackage

>>> sv/sfa_ctrl.sv
// command sequencer of the segment fit allocator
module sfa_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  sfa_pkg::t_sts i_sts,
    output logic         o_in_ready,
    output sfa_pkg::t_op  o_op
);
    import sfa_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISP      = 5'd1;
    localparam logic [4:0] S_INIT      = 5'd2;
    localparam logic [4:0] S_ALC_RD    = 5'd3;
    localparam logic [4:0] S_ALC_CHK   = 5'd4;
    localparam logic [4:0] S_ALC_SEL   = 5'd5;
    localparam logic [4:0] S_ALC_NXRD  = 5'd6;
    localparam logic [4:0] S_ALC_MERGE = 5'd7;
    localparam logic [4:0] S_SH_RD     = 5'd8;
    localparam logic [4:0] S_SH_WR     = 5'd9;
    localparam logic [4:0] S_ALC_INS   = 5'd10;
    localparam logic [4:0] S_REC_RD0   = 5'd11;
    localparam logic [4:0] S_REC_RD1   = 5'd12;
    localparam logic [4:0] S_REC_WR    = 5'd13;
    localparam logic [4:0] S_RM_RD     = 5'd14;
    localparam logic [4:0] S_RM_WR     = 5'd15;
    localparam logic [4:0] S_RM_FIN    = 5'd16;
    localparam logic [4:0] S_DUMP_RD   = 5'd17;
    localparam logic [4:0] S_DUMP_EM   = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.out_free) begin
                    case (i_sts.cmd)
                        CMD_INIT: begin
                            o_op    = OP_INIT_START;
                            n_state = S_INIT;
                        end
                        CMD_ALLOC: begin
                            o_op    = OP_ALC_START;
                            n_state = S_ALC_RD;
                        end
                        CMD_RECLAIM: begin
                            if (i_sts.bad_idx) begin
                                o_op    = OP_REC_BAD;
                                n_state = S_IDLE;
                            end else begin
                                o_op    = OP_REC_START;
                                n_state = S_REC_RD0;
                            end
                        end
                        default: begin
                            o_op    = OP_DUMP_START;
                            n_state = S_DUMP_RD;
                        end
                    endcase
                end
            end
            S_INIT: begin
                o_op = OP_INIT_STEP;
                if (i_sts.init_done) n_state = S_IDLE;
            end
            S_ALC_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_ALC_SEL;
                end else begin
                    o_op    = OP_RD_IDX;
                    n_state = S_ALC_CHK;
                end
            end
            S_ALC_CHK: begin
                o_op    = OP_ALC_CHK;
                n_state = i_sts.chk_stop ? S_ALC_SEL : S_ALC_RD;
            end
            S_ALC_SEL: begin
                o_op = OP_ALC_SEL;
                if (!i_sts.found || !i_sts.split) n_state = S_IDLE;
                else if (i_sts.merge_ok) n_state = S_ALC_NXRD;
                else if (i_sts.full) n_state = S_IDLE;
                else n_state = S_SH_RD;
            end
            S_ALC_NXRD: begin
                o_op    = OP_RD_NEXT;
                n_state = S_ALC_MERGE;
            end
            S_ALC_MERGE: begin
                o_op    = OP_ALC_MERGE;
                n_state = S_IDLE;
            end
            S_SH_RD: begin
                if (i_sts.sh_end) begin
                    n_state = S_ALC_INS;
                end else begin
                    o_op    = OP_RD_PREV;
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_op    = OP_SH_WR;
                n_state = S_SH_RD;
            end
            S_ALC_INS: begin
                o_op    = OP_ALC_INS;
                n_state = S_IDLE;
            end
            S_REC_RD0: begin
                o_op    = OP_RD_SEL;
                n_state = S_REC_RD1;
            end
            S_REC_RD1: begin
                o_op    = OP_REC_LATCH;
                n_state = (i_sts.dyn && i_sts.merge_ok) ? S_REC_WR : S_IDLE;
            end
            S_REC_WR: begin
                o_op    = OP_REC_MERGE;
                n_state = S_RM_RD;
            end
            S_RM_RD: begin
                if (i_sts.rm_end) begin
                    n_state = S_RM_FIN;
                end else begin
                    o_op    = OP_RD_AHEAD;
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_op    = OP_RM_WR;
                n_state = S_RM_RD;
            end
            S_RM_FIN: begin
                o_op    = OP_RM_FIN;
                n_state = S_IDLE;
            end
            S_DUMP_RD: begin
                o_op    = OP_RD_IDX;
                n_state = S_DUMP_EM;
            end
            S_DUMP_EM: begin
                if (i_sts.out_free) begin
                    o_op    = OP_DUMP_EM;
                    n_state = i_sts.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/sfa_dp.sv
// segment table, configuration, scan registers and result register
`include "assert_macros.svh"

module sfa_dp #(
    parameter int MAX_SEGMENTS = sfa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfa_pkg::t_op  i_op,
    output sfa_pkg::t_sts o_sts,
    input  logic [1:0]    i_cmd,
    input  logic [15:0]   i_request_size,
    input  logic [6:0]    i_target_index,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_status,
    output logic [6:0]    o_segment_position,
    output logic [15:0]   o_start_address,
    output logic [15:0]   o_segment_length,
    output logic          o_occupied,
    output logic          o_last
);
    import sfa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // table entry: start in the upper half, length in the lower half
    logic [31:0] mem [MAX_SEGMENTS];
    logic [31:0] r_rd;

    logic        r_mode;
    logic [1:0]  r_policy;
    logic [15:0] r_memsz, r_blksz;
    logic [1:0]  r_cmd;
    logic [15:0] r_req;
    logic [6:0]  r_tgt;

    logic [MAX_SEGMENTS-1:0] r_used, n_used;
    logic [CW-1:0] r_cnt, n_cnt, r_nfp, n_nfp, r_idx, n_idx;
    logic [IW-1:0] r_sel, n_sel;
    logic          r_found, n_found, r_trunc, n_trunc;
    logic [15:0]   r_best, n_best, r_sel_sa, n_sel_sa, r_sel_len, n_sel_len;
    logic [15:0]   r_rem, n_rem, r_addr, n_addr;

    logic        r_ov, n_ov;
    logic [2:0]  r_ost;
    logic [6:0]  r_opos;
    logic [15:0] r_osa, r_olen;
    logic        r_oocc, r_olast;

    logic          emit;
    logic [2:0]    e_st;
    logic [6:0]    e_pos;
    logic [15:0]   e_sa, e_len;
    logic          e_occ, e_last;
    logic          we, re;
    logic [IW-1:0] waddr, raddr;
    logic [31:0]   wdata;

    logic [15:0]   rd_sa, rd_len, bs, slack, newlen;
    logic [CW-1:0] sel_n1, sel_n2, idx_m1, idx_p1;
    logic [IW-1:0] idx_i, tsel;
    logic          dyn, hit, merge_ok, split, full, out_free, init_done, take;

    assign rd_sa    = r_rd[31:16];
    assign rd_len   = r_rd[15:0];
    assign dyn      = r_mode;
    assign bs       = (r_blksz == '0) ? 16'd1 : r_blksz;
    assign idx_i    = r_idx[IW-1:0];
    assign idx_m1   = r_idx - CW'(1);
    assign idx_p1   = r_idx + CW'(1);
    assign sel_n1   = CW'(r_sel) + CW'(1);
    assign sel_n2   = CW'(r_sel) + CW'(2);
    assign tsel     = IW'(r_tgt - 7'd1);
    assign slack    = rd_len - r_req;
    assign newlen   = r_sel_len + rd_len;
    assign hit      = !r_used[idx_i] && (rd_len >= r_req);
    assign merge_ok = (sel_n1 < r_cnt) && !r_used[sel_n1[IW-1:0]];
    assign split    = dyn && (r_sel_len > r_req);
    assign full     = (r_cnt >= CW'(MAX_SEGMENTS));
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        n_used = r_used;  n_cnt = r_cnt;  n_nfp = r_nfp;  n_idx = r_idx;
        n_sel = r_sel;  n_found = r_found;  n_trunc = r_trunc;  n_best = r_best;
        n_sel_sa = r_sel_sa;  n_sel_len = r_sel_len;  n_rem = r_rem;  n_addr = r_addr;
        we = 1'b0;  waddr = '0;  wdata = '0;  re = 1'b0;  raddr = '0;
        emit = 1'b0;  e_st = ST_ALLOC;  e_pos = '0;  e_sa = '0;  e_len = '0;
        e_occ = 1'b0;  e_last = 1'b1;  init_done = 1'b0;  take = 1'b0;
        case (i_op)
            OP_INIT_START: begin
                n_used  = '0;
                n_cnt   = '0;
                n_nfp   = '0;
                n_rem   = r_memsz;
                n_addr  = '0;
                n_trunc = 1'b0;
            end
            OP_INIT_STEP: begin
                if (!dyn && r_rem >= bs) begin
                    if (full) begin
                        n_trunc   = 1'b1;
                        init_done = 1'b1;
                    end else begin
                        we     = 1'b1;
                        waddr  = r_cnt[IW-1:0];
                        wdata  = {r_addr, bs};
                        n_addr = r_addr + bs;
                        n_rem  = r_rem - bs;
                        n_cnt  = r_cnt + CW'(1);
                    end
                end else if (!dyn && r_rem != '0) begin
                    if (full) begin
                        n_trunc = 1'b1;
                    end else begin
                        we    = 1'b1;
                        waddr = r_cnt[IW-1:0];
                        wdata = {r_addr, r_rem};
                        n_cnt = r_cnt + CW'(1);
                    end
                    init_done = 1'b1;
                end else begin
                    if (r_cnt == '0) begin
                        we    = 1'b1;
                        waddr = '0;
                        wdata = {16'd0, r_memsz};
                        n_cnt = CW'(1);
                    end
                    init_done = 1'b1;
                end
                if (init_done) begin
                    emit = 1'b1;
                    e_st = n_trunc ? ST_FULL : ST_INIT;
                end
            end
            OP_ALC_START: begin
                n_idx   = (r_policy == FIT_NEXT && r_nfp != '0) ? idx_m1_nfp(r_nfp) : '0;
                n_found = 1'b0;
                n_best  = UINT16_MAX;
            end
            OP_RD_IDX: begin
                re    = 1'b1;
                raddr = idx_i;
            end
            OP_ALC_CHK: begin
                if (hit) begin
                    if (r_policy == FIT_BEST) begin
                        if ((dyn && slack == '0) || slack <= r_best) begin
                            n_best = slack;
                            take   = 1'b1;
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                if (take) begin
                    n_sel     = idx_i;
                    n_found   = 1'b1;
                    n_sel_sa  = rd_sa;
                    n_sel_len = rd_len;
                end
                n_idx = idx_p1;
            end
            OP_ALC_SEL: begin
                if (!r_found) begin
                    emit = 1'b1;
                    e_st = ST_NOFIT;
                end else if (split) begin
                    if (!merge_ok && full) begin
                        emit = 1'b1;
                        e_st = ST_FULL;
                    end else begin
                        we    = 1'b1;
                        waddr = r_sel;
                        wdata = {r_sel_sa, r_req};
                        if (!merge_ok) n_idx = r_cnt;
                    end
                end else begin
                    n_used[r_sel] = 1'b1;
                    if (r_policy == FIT_NEXT) n_nfp = sel_n1;
                    emit  = 1'b1;
                    e_st  = ST_ALLOC;
                    e_pos = 7'(sel_n1);
                    e_sa  = r_sel_sa;
                    e_len = r_sel_len;
                    e_occ = 1'b1;
                end
            end
            OP_RD_NEXT: begin
                re    = 1'b1;
                raddr = sel_n1[IW-1:0];
            end
            OP_ALC_MERGE: begin
                we    = 1'b1;
                waddr = sel_n1[IW-1:0];
                wdata = {r_sel_sa + r_req, rd_len + (r_sel_len - r_req)};
                n_used[r_sel] = 1'b1;
                if (r_policy == FIT_NEXT) n_nfp = sel_n1;
                emit  = 1'b1;
                e_st  = ST_ALLOC;
                e_pos = 7'(sel_n1);
                e_sa  = r_sel_sa;
                e_len = r_req;
                e_occ = 1'b1;
            end
            OP_RD_PREV: begin
                re    = 1'b1;
                raddr = idx_m1[IW-1:0];
            end
            OP_SH_WR: begin
                we    = 1'b1;
                waddr = idx_i;
                wdata = r_rd;
                n_idx = idx_m1;
            end
            OP_ALC_INS: begin
                we    = 1'b1;
                waddr = sel_n1[IW-1:0];
                wdata = {r_sel_sa + r_req, r_sel_len - r_req};
                for (int j = 1; j < MAX_SEGMENTS; j++) begin
                    if (j > int'(r_sel) + 1) n_used[j] = r_used[j-1];
                end
                n_used[sel_n1[IW-1:0]] = 1'b0;
                n_used[r_sel]          = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_policy == FIT_NEXT) n_nfp = sel_n1;
                else if (r_nfp >= sel_n2) n_nfp = r_nfp + CW'(1);
                emit  = 1'b1;
                e_st  = ST_ALLOC;
                e_pos = 7'(sel_n1);
                e_sa  = r_sel_sa;
                e_len = r_req;
                e_occ = 1'b1;
            end
            OP_REC_BAD: begin
                emit = 1'b1;
                e_st = ST_BADIDX;
            end
            OP_REC_START: begin
                n_sel        = tsel;
                n_used[tsel] = 1'b0;
            end
            OP_RD_SEL: begin
                re    = 1'b1;
                raddr = r_sel;
            end
            OP_REC_LATCH: begin
                n_sel_sa  = rd_sa;
                n_sel_len = rd_len;
                if (dyn && merge_ok) begin
                    re    = 1'b1;
                    raddr = sel_n1[IW-1:0];
                end else begin
                    emit  = 1'b1;
                    e_st  = ST_RECLAIM;
                    e_pos = 7'(sel_n1);
                    e_sa  = rd_sa;
                    e_len = rd_len;
                end
            end
            OP_REC_MERGE: begin
                we        = 1'b1;
                waddr     = r_sel;
                wdata     = {r_sel_sa, newlen};
                n_sel_len = newlen;
                n_idx     = sel_n1;
            end
            OP_RD_AHEAD: begin
                re    = 1'b1;
                raddr = idx_p1[IW-1:0];
            end
            OP_RM_WR: begin
                we    = 1'b1;
                waddr = idx_i;
                wdata = r_rd;
                n_idx = idx_p1;
            end
            OP_RM_FIN: begin
                for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
                    if (j > int'(r_sel)) n_used[j] = r_used[j+1];
                end
                n_cnt = r_cnt - CW'(1);
                if (r_nfp > sel_n2) n_nfp = r_nfp - CW'(1);
                else if (r_nfp == sel_n2) n_nfp = sel_n1;
                emit  = 1'b1;
                e_st  = ST_RECLAIM;
                e_pos = 7'(sel_n1);
                e_sa  = r_sel_sa;
                e_len = r_sel_len;
            end
            OP_DUMP_START: begin
                n_idx = '0;
            end
            OP_DUMP_EM: begin
                emit   = 1'b1;
                e_st   = ST_DUMP;
                e_pos  = 7'(idx_p1);
                e_sa   = rd_sa;
                e_len  = rd_len;
                e_occ  = r_used[idx_i];
                e_last = o_sts.dump_last;
                n_idx  = idx_p1;
            end
            default: ;
        endcase
    end

    function automatic logic [CW-1:0] idx_m1_nfp(input logic [CW-1:0] p);
        return p - CW'(1);
    endfunction

    always_comb begin
        n_ov = emit ? 1'b1 : (r_ov && !i_out_ready);
    end

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.dyn       = dyn;
        o_sts.out_free  = out_free;
        o_sts.bad_idx   = (r_tgt == '0) || (32'(r_tgt) > 32'(r_cnt));
        o_sts.init_done = init_done;
        o_sts.scan_end  = (r_idx >= r_cnt);
        o_sts.chk_stop  = hit && (r_policy != FIT_BEST || (dyn && slack == '0));
        o_sts.found     = r_found;
        o_sts.split     = split;
        o_sts.merge_ok  = merge_ok;
        o_sts.full      = full;
        o_sts.sh_end    = (r_idx <= sel_n1);
        o_sts.rm_end    = ({1'b0, r_idx} + {{CW{1'b0}}, 1'b1}) >= {1'b0, r_cnt};
        o_sts.dump_last = (32'(r_idx) + 32'd1 == 32'(r_cnt))
                       || (32'(r_idx) + 32'd1 == 32'(RESULT_LIMIT));
    end

    // table memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_policy <= FIT_FIRST;
            r_memsz  <= 16'hFFFF;
            r_blksz  <= 16'd4096;
            r_used   <= '0;
            r_cnt    <= CW'(1);
            r_nfp    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_POLICY: r_policy <= i_cfg_data[1:0];
                    CFG_MEMSZ:  r_memsz  <= i_cfg_data;
                    CFG_BLKSZ:  r_blksz  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_used <= n_used;
            r_cnt  <= n_cnt;
            r_nfp  <= n_nfp;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_cmd <= i_cmd;
            r_req <= i_request_size;
            r_tgt <= i_target_index;
        end
        r_idx     <= n_idx;
        r_sel     <= n_sel;
        r_found   <= n_found;
        r_trunc   <= n_trunc;
        r_best    <= n_best;
        r_sel_sa  <= n_sel_sa;
        r_sel_len <= n_sel_len;
        r_rem     <= n_rem;
        r_addr    <= n_addr;
        if (emit) begin
            r_ost   <= e_st;
            r_opos  <= e_pos;
            r_osa   <= e_sa;
            r_olen  <= e_len;
            r_oocc  <= e_occ;
            r_olast <= e_last;
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_ov;
    assign o_status           = r_ost;
    assign o_segment_position = r_opos;
    assign o_start_address    = r_osa;
    assign o_segment_length   = r_olen;
    assign o_occupied         = r_oocc;
    assign o_last             = r_olast;

    `SFA_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, emit, !r_ov || i_out_ready, "result beat overwritten")
    `SFA_ASSERT_NXT(a_ins_grow, i_clk, i_rst_n, i_op == OP_ALC_INS, r_cnt == $past(r_cnt) + CW'(1), "insert did not grow table")
    `SFA_ASSERT_NXT(a_rm_shrink, i_clk, i_rst_n, i_op == OP_RM_FIN, r_cnt == $past(r_cnt) - CW'(1), "merge did not shrink table")

endmodule

>>> sv/segment_fit_allocator.sv
// top level of the segment fit allocator
// Keeps an address-ordered table of up to MAX_SEGMENTS segments in a single-port-read table
// memory and serves one command at a time; a new command is taken once the previous one has
// produced its last beat into the output register. Scans and shifts access the table as a read,
// then a check or a write: init writes one entry per step, allocate scans the entries and then
// shifts them up when a split inserts a new entry, reclaim shifts them down when a merge removes
// an entry, and dump emits one entry per beat (at most 64 beats) and waits out any output stall.
// Configuration writes are taken at any time and should only come while idle.
module segment_fit_allocator #(
    parameter int MAX_SEGMENTS = sfa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_request_size,
    input  logic [6:0]  i_target_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_segment_position,
    output logic [15:0] o_start_address,
    output logic [15:0] o_segment_length,
    output logic        o_occupied,
    output logic        o_last
);
    import sfa_pkg::*;

    t_op  op;
    t_sts sts;

    sfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_op       (op)
    );

    sfa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .o_sts              (sts),
        .i_cmd              (i_cmd),
        .i_request_size     (i_request_size),
        .i_target_index     (i_target_index),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_segment_position (o_segment_position),
        .o_start_address    (o_start_address),
        .o_segment_length   (o_segment_length),
        .o_occupied         (o_occupied),
        .o_last             (o_last)
    );

endmodule

>>> bench/segment_fit_allocator_tb.sv
// self-checking testbench for segment_fit_allocator with a scoreboard class and random idling
`timescale 1ns / 100ps

module segment_fit_allocator_tb;
    import sfa_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [6:0]  pos;
        logic [15:0] start;
        logic [15:0] len;
        logic        occ;
        logic        last;
    } seg_beat_t;

    class alloc_scoreboard;
        bit          mode;
        bit [1:0]    policy;
        int unsigned mem_sz;
        int unsigned blk_sz;
        bit [15:0]   seg_start[64];
        bit [15:0]   seg_len[64];
        bit          seg_used[64];
        int unsigned n_seg;
        int unsigned nf_pos;
        seg_beat_t   pending_q[$];
        int          errors;

        function new();
            mode = 1;
            policy = FIT_FIRST;
            mem_sz = 65535;
            blk_sz = 4096;
            n_seg = 1;
            nf_pos = 0;
            errors = 0;
            foreach (seg_used[k]) begin
                seg_start[k] = 0;
                seg_len[k] = 0;
                seg_used[k] = 0;
            end
        endfunction

        function void set_reg(bit [1:0] idx, bit [15:0] data);
            case (idx)
                CFG_MODE:   mode = data[0];
                CFG_POLICY: policy = data[1:0];
                CFG_MEMSZ:  mem_sz = data;
                default:    blk_sz = data;
            endcase
        endfunction

        function void push(bit [2:0] st, int unsigned pos, bit [15:0] sa, bit [15:0] len,
                           bit occ, bit last);
            seg_beat_t b;
            b.status = st;
            b.pos = pos[6:0];
            b.start = sa;
            b.len = len;
            b.occ = occ;
            b.last = last;
            pending_q.push_back(b);
        endfunction

        function void push_entry(bit [2:0] st, int unsigned i, bit last);
            push(st, i + 1, seg_start[i], seg_len[i], seg_used[i], last);
        endfunction

        function void build_table();
            int unsigned bs, k, n, rem;
            bit trunc;
            bs = (blk_sz != 0) ? blk_sz : 1;
            trunc = 0;
            n_seg = 0;
            nf_pos = 0;
            foreach (seg_used[j]) begin
                seg_start[j] = 0;
                seg_len[j] = 0;
                seg_used[j] = 0;
            end
            if (!mode) begin
                n = mem_sz / bs;
                rem = mem_sz % bs;
                for (k = 0; k < n; k++) begin
                    if (n_seg >= 64) begin
                        trunc = 1;
                        break;
                    end
                    seg_start[n_seg] = k * bs;
                    seg_len[n_seg] = bs;
                    n_seg++;
                end
                if (rem > 0) begin
                    if (n_seg >= 64) trunc = 1;
                    else begin
                        seg_start[n_seg] = n * bs;
                        seg_len[n_seg] = rem;
                        n_seg++;
                    end
                end
            end
            if (n_seg == 0) begin
                seg_start[0] = 0;
                seg_len[0] = mem_sz;
                n_seg = 1;
            end
            push(trunc ? ST_FULL : ST_INIT, 0, 0, 0, 0, 1);
        endfunction

        function void insert_after(int unsigned sel, bit [15:0] sa, bit [15:0] len);
            int unsigned j;
            for (j = n_seg; j > sel + 1; j--) begin
                seg_start[j] = seg_start[j-1];
                seg_len[j] = seg_len[j-1];
                seg_used[j] = seg_used[j-1];
            end
            seg_start[sel+1] = sa;
            seg_len[sel+1] = len;
            seg_used[sel+1] = 0;
            n_seg++;
            if (nf_pos >= sel + 2) nf_pos++;
        endfunction

        function void remove_at(int unsigned r);
            int unsigned j;
            for (j = r; j + 1 < n_seg; j++) begin
                seg_start[j] = seg_start[j+1];
                seg_len[j] = seg_len[j+1];
                seg_used[j] = seg_used[j+1];
            end
            n_seg--;
            if (nf_pos > r + 1) nf_pos--;
            else if (nf_pos == r + 1) nf_pos = r;
        endfunction

        function void allocate(int unsigned req);
            int unsigned i, sel, best, first, len, slack, rest;
            bit found, merge;
            bit [15:0] nsa;
            sel = 0;
            best = UINT16_MAX;
            first = 0;
            found = 0;
            if (policy == FIT_NEXT && nf_pos != 0) first = nf_pos - 1;
            for (i = first; i < n_seg && i < 64; i++) begin
                len = seg_len[i];
                if (seg_used[i] || len < req) continue;
                if (policy == FIT_BEST) begin
                    slack = len - req;
                    if (mode && slack == 0) begin
                        sel = i;
                        found = 1;
                        break;
                    end
                    if (slack <= best) begin
                        best = slack;
                        sel = i;
                        found = 1;
                    end
                end else begin
                    sel = i;
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                push(ST_NOFIT, 0, 0, 0, 0, 1);
                return;
            end
            if (mode && seg_len[sel] > req) begin
                rest = seg_len[sel] - req;
                nsa = seg_start[sel] + req[15:0];
                merge = (sel + 1 < n_seg) && !seg_used[sel+1];
                if (!merge && n_seg >= 64) begin
                    push(ST_FULL, 0, 0, 0, 0, 1);
                    return;
                end
                seg_len[sel] = req;
                if (merge) begin
                    seg_start[sel+1] = nsa;
                    seg_len[sel+1] = seg_len[sel+1] + rest[15:0];
                end else begin
                    insert_after(sel, nsa, rest[15:0]);
                end
            end
            seg_used[sel] = 1;
            if (policy == FIT_NEXT) nf_pos = sel + 1;
            push_entry(ST_ALLOC, sel, 1);
        endfunction

        function void reclaim(int unsigned t);
            int unsigned i;
            if (t == 0 || t > n_seg) begin
                push(ST_BADIDX, 0, 0, 0, 0, 1);
                return;
            end
            i = t - 1;
            seg_used[i] = 0;
            if (mode && i + 1 < n_seg && !seg_used[i+1]) begin
                seg_len[i] = seg_len[i] + seg_len[i+1];
                remove_at(i + 1);
            end
            push_entry(ST_RECLAIM, i, 1);
        endfunction

        function void note_command(bit [1:0] cmd, bit [15:0] req, bit [6:0] tgt);
            int unsigned n;
            case (cmd)
                CMD_ALLOC:   allocate(req);
                CMD_RECLAIM: reclaim(tgt);
                CMD_DUMP: begin
                    n = (n_seg > RESULT_LIMIT) ? RESULT_LIMIT : n_seg;
                    for (int unsigned i = 0; i < n; i++) push_entry(ST_DUMP, i, i + 1 == n);
                end
                default:     build_table();
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(seg_beat_t got);
            seg_beat_t w;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected beat status %0d", got.status));
                return;
            end
            w = pending_q.pop_front();
            if (got.status !== w.status)
                report($sformatf("status %0d want %0d", got.status, w.status));
            if (got.pos !== w.pos)
                report($sformatf("position %0d want %0d", got.pos, w.pos));
            if (got.start !== w.start)
                report($sformatf("start %0d want %0d", got.start, w.start));
            if (got.len !== w.len)
                report($sformatf("length %0d want %0d", got.len, w.len));
            if (got.occ !== w.occ)
                report($sformatf("occupied %0b want %0b", got.occ, w.occ));
            if (got.last !== w.last)
                report($sformatf("last %0b want %0b", got.last, w.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [15:0] i_request_size;
    logic [6:0]  i_target_index;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [6:0]  o_segment_position;
    logic [15:0] o_start_address;
    logic [15:0] o_segment_length;
    logic        o_occupied;
    logic        o_last;

    alloc_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    segment_fit_allocator u_dut (.*);

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // output side: stall at random, long hold-off on request
    always @(posedge i_clk) begin
        seg_beat_t got;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.status = o_status;
                got.pos = o_segment_position;
                got.start = o_start_address;
                got.len = o_segment_length;
                got.occ = o_occupied;
                got.last = o_last;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic wait_drained();
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [15:0] req, logic [6:0] tgt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_cmd <= cmd;
        i_request_size <= req;
        i_target_index <= tgt;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd, req, tgt);
    endtask

    task automatic setup(bit mode, logic [1:0] pol, logic [15:0] mem, logic [15:0] blk);
        wait_drained();
        write_reg(CFG_MODE, {15'd0, mode});
        write_reg(CFG_POLICY, {14'd0, pol});
        write_reg(CFG_MEMSZ, mem);
        write_reg(CFG_BLKSZ, blk);
        send_cmd(CMD_INIT, $urandom, $urandom);
    endtask

    task automatic random_cmd();
        int r;
        int unsigned span;
        logic [15:0] req;
        logic [6:0] tgt;
        r = $urandom_range(0, 99);
        span = sb.mem_sz / 6;
        if (span == 0) span = 1;
        case ($urandom_range(0, 9))
            0: req = $urandom;
            1: req = 0;
            default: req = $urandom_range(0, span);
        endcase
        case ($urandom_range(0, 9))
            0: tgt = $urandom_range(0, 64);
            1: tgt = 0;
            default: tgt = $urandom_range(1, sb.n_seg + 1);
        endcase
        if (r < 50) send_cmd(CMD_ALLOC, req, tgt);
        else if (r < 86) send_cmd(CMD_RECLAIM, req, tgt);
        else if (r < 96) send_cmd(CMD_DUMP, req, tgt);
        else send_cmd(CMD_INIT, req, tgt);
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_cmd = CMD_INIT;
        i_request_size = 0;
        i_target_index = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero request, whole-memory fit, bad indexes, merge, dump
        setup(1, FIT_FIRST, 16'd65535, 16'd4096);
        send_cmd(CMD_ALLOC, 16'd0, 7'd0);
        send_cmd(CMD_ALLOC, 16'hFFFF, 7'd0);
        send_cmd(CMD_ALLOC, 16'd1, 7'd0);
        send_cmd(CMD_RECLAIM, 16'd0, 7'd0);
        send_cmd(CMD_RECLAIM, 16'd0, 7'd64);
        send_cmd(CMD_RECLAIM, 16'd0, 7'd2);
        send_cmd(CMD_RECLAIM, 16'd0, 7'd1);
        send_cmd(CMD_DUMP, 16'd0, 7'd0);
        setup(0, FIT_BEST, 16'd65535, 16'd1);
        send_cmd(CMD_ALLOC, 16'd1, 7'd0);
        send_cmd(CMD_ALLOC, 16'd2, 7'd0);
        send_cmd(CMD_RECLAIM, 16'd0, 7'd64);
        setup(0, FIT_FIRST, 16'd100, 16'd65535);
        send_cmd(CMD_ALLOC, 16'd50, 7'd0);
        send_cmd(CMD_DUMP, 16'd0, 7'd0);
        setup(1, FIT_BEST, 16'd1, 16'd1);
        send_cmd(CMD_ALLOC, 16'd1, 7'd0);
        send_cmd(CMD_ALLOC, 16'd0, 7'd0);

        // fill the table with unit splits until it reports full, then long dump
        setup(1, FIT_FIRST, 16'd100, 16'd7);
        repeat (66) send_cmd(CMD_ALLOC, 16'd1, 7'd0);
        send_cmd(CMD_DUMP, 16'd0, 7'd0);
        repeat (8) send_cmd(CMD_RECLAIM, 16'd0, $urandom_range(1, 64));

        setup(0, FIT_BEST, 16'd5000, 16'd300);
        repeat (40) random_cmd();

        send_idle_pct = 83;
        setup(1, FIT_NEXT, 16'd1000, 16'd65535);
        repeat (40) random_cmd();

        send_idle_pct = 0;
        recv_stall_pct = 83;
        setup(0, FIT_NEXT, 16'd3000, 16'd250);
        repeat (40) random_cmd();

        send_idle_pct = 30;
        recv_stall_pct = 30;
        setup(1, FIT_BEST, 16'd4000, 16'd4096);
        @(negedge i_clk);
        hold_left = 3000;
        send_idle_pct = 0;
        repeat (12) random_cmd();
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        send_idle_pct = 30;
        repeat (40) random_cmd();

        wait_drained();
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/sfa_pkg.sv
sv/sfa_ctrl.sv
sv/sfa_dp.sv
sv/segment_fit_allocator.sv
bench/segment_fit_allocator_tb.sv
